// ===== src/qps_pkg.sv =====
`default_nettype none

package qps_pkg;

  // score precision, fraction bits of the normalized metrics and the blend
  localparam int unsigned SCORE_FRAC_BITS = 16;

  localparam int unsigned ID_W        = 16;
  localparam int unsigned METRIC_W    = 32;
  localparam int unsigned LOSS_W      = 16;
  localparam int unsigned WEIGHT_W    = 16;
  localparam int unsigned OUT_SCORE_W = 17;

  localparam int unsigned SCORE_W = SCORE_FRAC_BITS + 1;
  localparam int unsigned QUOT_W  = SCORE_FRAC_BITS + 1;
  localparam int unsigned DVD_W   = METRIC_W + QUOT_W;
  localparam int unsigned WSUM_W  = WEIGHT_W + 2;
  localparam int unsigned PROD_W  = SCORE_FRAC_BITS + WEIGHT_W;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned CNT_W   = $clog2(QUOT_W + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [SCORE_W-1:0] SCORE_ONE = {1'b1, {SCORE_FRAC_BITS{1'b0}}};

  localparam logic [METRIC_W-1:0] LAT_LIMIT_RST  = 32'd50000;
  localparam logic [METRIC_W-1:0] JIT_LIMIT_RST  = 32'd10000;
  localparam logic [LOSS_W-1:0]   LOSS_LIMIT_RST = 16'd655;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST     = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAT_LIMIT  = 3'd0,
    CFG_JIT_LIMIT  = 3'd1,
    CFG_LOSS_LIMIT = 3'd2,
    CFG_W_LAT      = 3'd3,
    CFG_W_JIT      = 3'd4,
    CFG_W_LOSS     = 3'd5,
    CFG_REQ_COMP   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [METRIC_W-1:0] lat_limit;
    logic [METRIC_W-1:0] jit_limit;
    logic [LOSS_W-1:0]   loss_limit;
    logic [WEIGHT_W-1:0] w_lat;
    logic [WEIGHT_W-1:0] w_jit;
    logic [WEIGHT_W-1:0] w_loss;
    logic                require_comp;
  } cfg_t;

  // one scored candidate handed from the sequencer to the selector
  typedef struct packed {
    logic               fire;
    logic               last;
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
    logic               comp;
  } upd_t;

  localparam int unsigned TQ_W = SCORE_W + 16;
  localparam int unsigned TQ_SHR = (SCORE_FRAC_BITS >= 16) ? SCORE_FRAC_BITS - 16 : 0;
  localparam int unsigned TQ_SHL = (SCORE_FRAC_BITS < 16) ? 16 - SCORE_FRAC_BITS : 0;

  function automatic logic [OUT_SCORE_W-1:0] to_q16(input logic [SCORE_W-1:0] s);
    logic [TQ_W-1:0] t;
    t = TQ_W'(s) << TQ_SHL;
    return OUT_SCORE_W'(t >> TQ_SHR);
  endfunction

endpackage

`default_nettype wire

// ===== src/qps_if.sv =====
`default_nettype none

interface qps_in_if;
  import qps_pkg::*;
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     path_id;
  logic [METRIC_W-1:0] path_latency;
  logic [METRIC_W-1:0] path_jitter;
  logic [LOSS_W-1:0]   loss_frac;
  logic                last_path;
  modport source (output valid, path_id, path_latency, path_jitter, loss_frac, last_path,
                  input ready);
  modport sink (input valid, path_id, path_latency, path_jitter, loss_frac, last_path,
                output ready);
endinterface

interface qps_out_if;
  import qps_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [ID_W-1:0]        best_path_id;
  logic [OUT_SCORE_W-1:0] best_score;
  logic                   best_compliant;
  modport source (output valid, best_path_id, best_score, best_compliant, input ready);
  modport sink (input valid, best_path_id, best_score, best_compliant, output ready);
endinterface

interface qps_cfg_if;
  import qps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/qos_path_score_select.sv =====
`default_nettype none

// Scores candidate paths one word at a time and returns the best of each set.
// Each candidate is taken only while the block is idle. Scoring runs through one
// shared radix-2 divider: three metric normalizations (limit/value) and the
// final weighted-sum division, 17 steps each plus a load and a done step,
// together with three multiply and accumulate passes (multiply, then
// accumulate) through one 17x16 multiplier, and a final state that hands the
// score to the selector. The block takes no new candidate while one is being
// scored. A result word is
// produced only for the candidate marked last; it sits in an output register,
// and a last candidate waits in its final state only if that register still
// holds an untaken result. Configuration writes are taken at any time but
// belong between sets; limits and weights are read throughout scoring. Reset
// leaves the selection state empty.
module qos_path_score_select (
  input  logic      clk_i,
  input  logic      rst_ni,
  qps_cfg_if.sink   cfg_i,
  qps_in_if.sink    in_i,
  qps_out_if.source out_o
);
  import qps_pkg::*;

  cfg_t                cfg;
  upd_t                upd;
  logic                out_free;
  logic                div_start, div_done;
  logic [DVD_W-1:0]    div_dividend;
  logic [METRIC_W-1:0] div_divisor;
  logic [QUOT_W-1:0]   div_quot;

  qps_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  qps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  qps_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .cfg_i          (cfg),
    .out_free_i     (out_free),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quot_i     (div_quot),
    .upd_o          (upd)
  );

  qps_sel u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .require_i  (cfg.require_comp),
    .out_free_o (out_free),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// ===== src/qps_cfg.sv =====
`default_nettype none

module qps_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  qps_cfg_if.sink       cfg_i,
  output qps_pkg::cfg_t cfg_o
);
  import qps_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_LAT_LIMIT:  cfg_d.lat_limit    = cfg_i.data[METRIC_W-1:0];
        CFG_JIT_LIMIT:  cfg_d.jit_limit    = cfg_i.data[METRIC_W-1:0];
        CFG_LOSS_LIMIT: cfg_d.loss_limit   = cfg_i.data[LOSS_W-1:0];
        CFG_W_LAT:      cfg_d.w_lat        = cfg_i.data[WEIGHT_W-1:0];
        CFG_W_JIT:      cfg_d.w_jit        = cfg_i.data[WEIGHT_W-1:0];
        CFG_W_LOSS:     cfg_d.w_loss       = cfg_i.data[WEIGHT_W-1:0];
        CFG_REQ_COMP:   cfg_d.require_comp = cfg_i.data[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lat_limit    <= LAT_LIMIT_RST;
      cfg_q.jit_limit    <= JIT_LIMIT_RST;
      cfg_q.loss_limit   <= LOSS_LIMIT_RST;
      cfg_q.w_lat        <= WEIGHT_RST;
      cfg_q.w_jit        <= WEIGHT_RST;
      cfg_q.w_loss       <= WEIGHT_RST;
      cfg_q.require_comp <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/qps_div.sv =====
`default_nettype none

module qps_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [qps_pkg::DVD_W-1:0]    dividend_i,
  input  logic [qps_pkg::METRIC_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [qps_pkg::QUOT_W-1:0]   quot_o
);
  import qps_pkg::*;

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [METRIC_W-1:0] rem_q;
  logic [METRIC_W-1:0] dsr_q;
  logic [QUOT_W-1:0] quot_q;

  logic [METRIC_W:0] trial;
  logic [METRIC_W:0] diff;
  logic              ge;

  // restoring step: dividend bits shift out of the top of quot_q while
  // quotient bits shift in at the bottom
  assign trial = {rem_q, quot_q[QUOT_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QUOT_W);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i[DVD_W-1:QUOT_W];
      quot_q <= dividend_i[QUOT_W-1:0];
      dsr_q  <= divisor_i;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q  <= ge ? diff[METRIC_W-1:0] : trial[METRIC_W-1:0];
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== src/qps_seq.sv =====
`default_nettype none

module qps_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  qps_in_if.sink                       in_i,
  input  qps_pkg::cfg_t                cfg_i,
  input  logic                         out_free_i,
  output logic                         div_start_o,
  output logic [qps_pkg::DVD_W-1:0]    div_dividend_o,
  output logic [qps_pkg::METRIC_W-1:0] div_divisor_o,
  input  logic                         div_done_i,
  input  logic [qps_pkg::QUOT_W-1:0]   div_quot_i,
  output qps_pkg::upd_t                upd_o
);
  import qps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DLOAD, S_DWAIT, S_MUL, S_ACC, S_SLOAD, S_SWAIT, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    MET_LAT, MET_JIT, MET_LOSS
  } metric_e;

  state_e  state_q;
  metric_e met_q;

  logic [ID_W-1:0]     id_q;
  logic [METRIC_W-1:0] lat_q;
  logic [METRIC_W-1:0] jit_q;
  logic [LOSS_W-1:0]   loss_q;
  logic                last_q;
  logic                comp_q;
  logic [SCORE_W-1:0]  n_lat_q, n_jit_q, n_loss_q;
  logic [PROD_W-1:0]   prod_q;
  logic [ACC_W-1:0]    acc_q;
  logic [SCORE_W-1:0]  score_q;

  logic                accept;
  logic                fire;
  logic [METRIC_W-1:0] met_val, met_lim;
  logic [WEIGHT_W-1:0] met_w;
  logic [SCORE_W-1:0]  met_n, norm;
  logic [WSUM_W-1:0]   wsum;
  logic [SCORE_W+WEIGHT_W-1:0] mul_full;
  metric_e             met_next;
  logic                comp_in;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && (state_q == S_IDLE);
  assign fire       = (state_q == S_FIN) && (!last_q || out_free_i);

  always_comb begin
    case (met_q)
      MET_LAT: begin
        met_val  = lat_q;
        met_lim  = cfg_i.lat_limit;
        met_w    = cfg_i.w_lat;
        met_n    = n_lat_q;
        met_next = MET_JIT;
      end
      MET_JIT: begin
        met_val  = jit_q;
        met_lim  = cfg_i.jit_limit;
        met_w    = cfg_i.w_jit;
        met_n    = n_jit_q;
        met_next = MET_LOSS;
      end
      default: begin
        met_val  = METRIC_W'(loss_q);
        met_lim  = METRIC_W'(cfg_i.loss_limit);
        met_w    = cfg_i.w_loss;
        met_n    = n_loss_q;
        met_next = MET_LAT;
      end
    endcase
  end

  assign wsum = WSUM_W'(cfg_i.w_lat) + WSUM_W'(cfg_i.w_jit) + WSUM_W'(cfg_i.w_loss);

  // quotient is only meaningful when value > limit > 0
  assign norm = (met_lim == '0) ? '0 :
                (met_val <= met_lim) ? SCORE_ONE : SCORE_W'(div_quot_i);

  assign mul_full = met_n * met_w;

  assign comp_in = (in_i.path_latency <= cfg_i.lat_limit) &&
                   (in_i.path_jitter <= cfg_i.jit_limit) &&
                   (in_i.loss_frac <= cfg_i.loss_limit);

  assign div_start_o    = (state_q == S_DLOAD) || (state_q == S_SLOAD);
  assign div_dividend_o = (state_q == S_SLOAD) ? DVD_W'(acc_q)
                                               : DVD_W'(met_lim) << SCORE_FRAC_BITS;
  assign div_divisor_o  = (state_q == S_SLOAD) ? METRIC_W'(wsum) : met_val;

  assign upd_o.fire  = fire;
  assign upd_o.last  = last_q;
  assign upd_o.id    = id_q;
  assign upd_o.score = score_q;
  assign upd_o.comp  = comp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      met_q   <= MET_LAT;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            met_q   <= MET_LAT;
            state_q <= S_DLOAD;
          end
        end
        S_DLOAD: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_done_i) begin
            met_q   <= met_next;
            state_q <= (met_q == MET_LOSS) ? S_MUL : S_DLOAD;
          end
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          met_q   <= met_next;
          state_q <= (met_q == MET_LOSS) ? S_SLOAD : S_MUL;
        end
        S_SLOAD: state_q <= S_SWAIT;
        S_SWAIT: begin
          if (div_done_i) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (fire) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q   <= in_i.path_id;
      lat_q  <= in_i.path_latency;
      jit_q  <= in_i.path_jitter;
      loss_q <= in_i.loss_frac;
      last_q <= in_i.last_path;
      comp_q <= comp_in;
      acc_q  <= '0;
    end
    if ((state_q == S_DWAIT) && div_done_i) begin
      case (met_q)
        MET_LAT: n_lat_q  <= norm;
        MET_JIT: n_jit_q  <= norm;
        default: n_loss_q <= norm;
      endcase
    end
    if (state_q == S_MUL) begin
      prod_q <= mul_full[PROD_W-1:0];
    end
    if (state_q == S_ACC) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if ((state_q == S_SWAIT) && div_done_i) begin
      score_q <= (wsum == '0) ? '0 : SCORE_W'(div_quot_i);
    end
  end

endmodule

`default_nettype wire

// ===== src/qps_sel.sv =====
`default_nettype none

module qps_sel (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  qps_pkg::upd_t upd_i,
  input  logic          require_i,
  output logic          out_free_o,
  qps_out_if.source     out_o
);
  import qps_pkg::*;

  logic               ok_valid_q, any_valid_q, out_valid_q;
  logic [ID_W-1:0]    ok_id_q, any_id_q;
  logic [SCORE_W-1:0] ok_score_q, any_score_q;
  logic               any_comp_q;
  logic [ID_W-1:0]        out_id_q;
  logic [OUT_SCORE_W-1:0] out_score_q;
  logic                   out_comp_q;

  logic               take_ok, take_any, use_ok;
  logic [ID_W-1:0]    ok_id_n, any_id_n;
  logic [SCORE_W-1:0] ok_score_n, any_score_n;
  logic               any_comp_n;

  // ties keep the earlier path
  assign take_ok  = upd_i.comp && (!ok_valid_q || (upd_i.score > ok_score_q));
  assign take_any = !any_valid_q || (upd_i.score > any_score_q);

  assign ok_id_n     = take_ok ? upd_i.id : ok_id_q;
  assign ok_score_n  = take_ok ? upd_i.score : ok_score_q;
  assign any_id_n    = take_any ? upd_i.id : any_id_q;
  assign any_score_n = take_any ? upd_i.score : any_score_q;
  assign any_comp_n  = take_any ? upd_i.comp : any_comp_q;
  assign use_ok      = require_i && (ok_valid_q || take_ok);

  assign out_free_o           = !out_valid_q || out_o.ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.best_path_id   = out_id_q;
  assign out_o.best_score     = out_score_q;
  assign out_o.best_compliant = out_comp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_valid_q  <= 1'b0;
      any_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (upd_i.fire) begin
        ok_valid_q  <= !upd_i.last && (ok_valid_q || take_ok);
        any_valid_q <= !upd_i.last;
      end
      if (upd_i.fire && upd_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.fire) begin
      ok_id_q     <= ok_id_n;
      ok_score_q  <= ok_score_n;
      any_id_q    <= any_id_n;
      any_score_q <= any_score_n;
      any_comp_q  <= any_comp_n;
      if (upd_i.last) begin
        out_id_q    <= use_ok ? ok_id_n : any_id_n;
        out_score_q <= to_q16(use_ok ? ok_score_n : any_score_n);
        out_comp_q  <= use_ok ? 1'b1 : any_comp_n;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/qps_checker.sv =====
`default_nettype none

module qps_props (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [qps_pkg::ID_W-1:0]        best_path_id_i,
  input logic [qps_pkg::OUT_SCORE_W-1:0] best_score_i
);

  // scoring keeps the input not ready after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i ##1 !in_ready_i)
    else $error("input taken again too soon after a word");

  // a result appears only as a scoring pass ends
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while the block was idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      out_valid_i && $stable(best_score_i) && $stable(best_path_id_i))
    else $error("stalled result changed");

  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (best_score_i <= 17'd65536))
    else $error("score above 1.0");

endmodule

bind qos_path_score_select qps_props u_qps_props (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .best_path_id_i (out_o.best_path_id),
  .best_score_i   (out_o.best_score)
);

`default_nettype wire

// ===== bench/qps_checker.sv =====
`timescale 1ns / 100ps

module qps_checker
  import qps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  qps_cfg_if   cfg_i,
  qps_in_if    in_i,
  qps_out_if   res_i,
  output int   fails_o,
  output int   pending_o
);

  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic [OUT_SCORE_W-1:0] score;
    logic                   comp;
  } pick_t;

  cfg_t  regs;
  pick_t picks_due[$];
  pick_t want;
  int    fails = 0;

  // best compliant candidate of the open set
  logic               ok_held;
  logic [ID_W-1:0]    ok_id;
  logic [SCORE_W-1:0] ok_score;
  // best candidate of the open set, compliant or not
  logic               top_held;
  logic [ID_W-1:0]    top_id;
  logic [SCORE_W-1:0] top_score;
  logic               top_comp;

  function automatic logic [SCORE_W-1:0] headroom(input logic [63:0] value,
                                                  input logic [63:0] limit);
    logic [63:0] q;
    if (limit == 0) return '0;
    if (value <= limit) return SCORE_ONE;
    q = (limit << SCORE_FRAC_BITS) / value;
    return q[SCORE_W-1:0];
  endfunction

  function automatic logic [OUT_SCORE_W-1:0] rescale_q16(input logic [SCORE_W-1:0] s);
    logic [63:0] w;
    w = 64'(s);
    if (SCORE_FRAC_BITS >= 16) begin
      w = w >> (SCORE_FRAC_BITS - 16);
    end else begin
      w = w << (16 - SCORE_FRAC_BITS);
    end
    return w[OUT_SCORE_W-1:0];
  endfunction

  task automatic clear_set();
    ok_held   = 1'b0;
    ok_id     = '0;
    ok_score  = '0;
    top_held  = 1'b0;
    top_id    = '0;
    top_score = '0;
    top_comp  = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_LAT_LIMIT:  regs.lat_limit = data[METRIC_W-1:0];
      CFG_JIT_LIMIT:  regs.jit_limit = data[METRIC_W-1:0];
      CFG_LOSS_LIMIT: regs.loss_limit = data[LOSS_W-1:0];
      CFG_W_LAT:      regs.w_lat = data[WEIGHT_W-1:0];
      CFG_W_JIT:      regs.w_jit = data[WEIGHT_W-1:0];
      CFG_W_LOSS:     regs.w_loss = data[WEIGHT_W-1:0];
      CFG_REQ_COMP:   regs.require_comp = data[0];
      default: ;
    endcase
  endtask

  task automatic take_candidate(input logic [ID_W-1:0] id, input logic [METRIC_W-1:0] lat,
                                input logic [METRIC_W-1:0] jit, input logic [LOSS_W-1:0] loss,
                                input logic last);
    logic [63:0]        nl, nj, nx, wsum, blend;
    logic [SCORE_W-1:0] score;
    logic               comp;
    pick_t              p;
    nl    = 64'(headroom(64'(lat), 64'(regs.lat_limit)));
    nj    = 64'(headroom(64'(jit), 64'(regs.jit_limit)));
    nx    = 64'(headroom(64'(loss), 64'(regs.loss_limit)));
    wsum  = 64'(regs.w_lat) + 64'(regs.w_jit) + 64'(regs.w_loss);
    blend = nl * 64'(regs.w_lat) + nj * 64'(regs.w_jit) + nx * 64'(regs.w_loss);
    score = (wsum == 0) ? '0 : SCORE_W'(blend / wsum);
    comp  = (lat <= regs.lat_limit) && (jit <= regs.jit_limit) && (loss <= regs.loss_limit);
    // equal scores never displace the earlier holder
    if (comp && (!ok_held || score > ok_score)) begin
      ok_held  = 1'b1;
      ok_id    = id;
      ok_score = score;
    end
    if (!top_held || score > top_score) begin
      top_held  = 1'b1;
      top_id    = id;
      top_score = score;
      top_comp  = comp;
    end
    if (last) begin
      if (regs.require_comp && ok_held) begin
        p.id    = ok_id;
        p.score = rescale_q16(ok_score);
        p.comp  = 1'b1;
      end else begin
        p.id    = top_id;
        p.score = rescale_q16(top_score);
        p.comp  = top_comp;
      end
      picks_due.push_back(p);
      clear_set();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.lat_limit    = LAT_LIMIT_RST;
      regs.jit_limit    = JIT_LIMIT_RST;
      regs.loss_limit   = LOSS_LIMIT_RST;
      regs.w_lat        = WEIGHT_RST;
      regs.w_jit        = WEIGHT_RST;
      regs.w_loss       = WEIGHT_RST;
      regs.require_comp = 1'b0;
      clear_set();
      picks_due.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        write_reg(cfg_i.index, cfg_i.data);
      end
      if (res_i.valid && res_i.ready) begin
        if (picks_due.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected result word: expected none, got id %h score %h comp %b",
                     res_i.best_path_id, res_i.best_score, res_i.best_compliant);
          end
        end else begin
          want = picks_due.pop_front();
          if (res_i.best_path_id !== want.id || res_i.best_score !== want.score ||
              res_i.best_compliant !== want.comp) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: expected id %h score %h comp %b, got id %h score %h comp %b",
                       want.id, want.score, want.comp,
                       res_i.best_path_id, res_i.best_score, res_i.best_compliant);
            end
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        take_candidate(in_i.path_id, in_i.path_latency, in_i.path_jitter, in_i.loss_frac,
                       in_i.last_path);
      end
    end
    pending_o <= picks_due.size();
    fails_o   <= fails;
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import qps_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 20000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned ITEM_TARGET   = 1200;
  localparam int unsigned CALM_FROM     = 1050;
  localparam int unsigned LONG_HOLD     = 1500;
  // no register sits behind this index
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  qps_cfg_if cfg_ch();
  qps_in_if  path_ch();
  qps_out_if pick_ch();

  int fails;
  int pending;
  int idle_cycles = 0;
  int items_sent  = 0;
  int hold_req    = 0;
  int phase_no    = 0;
  bit calm        = 1'b0;

  logic [METRIC_W-1:0] lat_lim;
  logic [METRIC_W-1:0] jit_lim;
  logic [LOSS_W-1:0]   loss_lim;

  qos_path_score_select u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (path_ch),
    .out_o  (pick_ch)
  );

  qps_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_ch),
    .in_i      (path_ch),
    .res_i     (pick_ch),
    .fails_o   (fails),
    .pending_o (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((cfg_ch.valid && cfg_ch.ready) || (path_ch.valid && path_ch.ready) ||
        (pick_ch.valid && pick_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    pick_ch.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        pick_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 10);
        pick_ch.ready <= 1'b0;
      end else begin
        n = $urandom_range(1, 20);
        pick_ch.ready <= 1'b1;
      end
      repeat (n) @(posedge clk_i);
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      CFG_LAT_LIMIT:  lat_lim = data[METRIC_W-1:0];
      CFG_JIT_LIMIT:  jit_lim = data[METRIC_W-1:0];
      CFG_LOSS_LIMIT: loss_lim = data[LOSS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(input logic [ID_W-1:0] id, input logic [METRIC_W-1:0] lat,
                           input logic [METRIC_W-1:0] jit, input logic [LOSS_W-1:0] loss,
                           input logic last);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      path_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    path_ch.valid        <= 1'b1;
    path_ch.path_id      <= id;
    path_ch.path_latency <= lat;
    path_ch.path_jitter  <= jit;
    path_ch.loss_frac    <= loss;
    path_ch.last_path    <= last;
    @(posedge clk_i);
    while (!path_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // wait for every outstanding result word, then let the block settle
  task automatic drain();
    path_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [METRIC_W-1:0] near_limit(input logic [METRIC_W-1:0] lim);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return lim;
      2:       return lim + 1;
      3:       return lim - 1;
      4:       return '1;
      5, 6:    return $urandom;
      default: return (lim < 32'h8000_0000) ? $urandom_range(0, 2 * lim) : $urandom;
    endcase
  endfunction

  function automatic logic [LOSS_W-1:0] near_loss(input logic [LOSS_W-1:0] lim);
    int unsigned top;
    top = (lim < 16'h8000) ? 2 * lim : 65535;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return lim;
      2:       return LOSS_W'(lim + 1);
      3:       return LOSS_W'(lim - 1);
      4:       return '1;
      5, 6:    return LOSS_W'($urandom_range(0, 65535));
      default: return LOSS_W'($urandom_range(0, top));
    endcase
  endfunction

  function automatic logic [METRIC_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(1, 1000);
      3:       return $urandom_range(1000, 200000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return WEIGHT_RST;
      3:       return WEIGHT_W'($urandom_range(1, 8));
      default: return WEIGHT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // upper data bits of the narrow registers carry junk
  function automatic logic [CFG_DATA_W-1:0] pad16(input logic [15:0] v);
    return {16'($urandom), v};
  endfunction

  task automatic random_config();
    if ($urandom_range(0, 1)) cfg_write(CFG_LAT_LIMIT, pick_limit());
    if ($urandom_range(0, 1)) cfg_write(CFG_JIT_LIMIT, pick_limit());
    if ($urandom_range(0, 1)) cfg_write(CFG_LOSS_LIMIT, pad16(LOSS_W'(pick_limit())));
    if ($urandom_range(0, 9) == 0) begin
      cfg_write(CFG_W_LAT, pad16('0));
      cfg_write(CFG_W_JIT, pad16('0));
      cfg_write(CFG_W_LOSS, pad16('0));
    end else begin
      if ($urandom_range(0, 1)) cfg_write(CFG_W_LAT, pad16(pick_weight()));
      if ($urandom_range(0, 1)) cfg_write(CFG_W_JIT, pad16(pick_weight()));
      if ($urandom_range(0, 1)) cfg_write(CFG_W_LOSS, pad16(pick_weight()));
    end
    if ($urandom_range(0, 7) == 0) cfg_write(CFG_NONE, $urandom);
    cfg_write(CFG_REQ_COMP, {31'($urandom), 1'($urandom_range(0, 1))});
    cfg_close();
  endtask

  task automatic random_sets(input int sets);
    int len;
    repeat (sets) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
      for (int k = 1; k <= len; k++) begin
        send_item(ID_W'($urandom_range(0, 65535)), near_limit(lat_lim), near_limit(jit_lim),
                  near_loss(loss_lim), k == len);
      end
    end
    drain();
  endtask

  initial begin
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_LAT_LIMIT;
    cfg_ch.data          = '0;
    path_ch.valid        = 1'b0;
    path_ch.path_id      = '0;
    path_ch.path_latency = '0;
    path_ch.path_jitter  = '0;
    path_ch.loss_frac    = '0;
    path_ch.last_path    = 1'b0;
    lat_lim  = LAT_LIMIT_RST;
    jit_lim  = JIT_LIMIT_RST;
    loss_lim = LOSS_LIMIT_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limits: lone candidate, extremes, exact limits and a tie
    send_item(16'h0000, 32'd0, 32'd0, 16'd0, 1'b1);
    send_item(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_item(16'h1234, 32'd50000, 32'd10000, 16'd655, 1'b0);
    send_item(16'h0005, 32'd50000, 32'd10000, 16'd655, 1'b0);
    send_item(16'h0007, 32'd50001, 32'd9999, 16'd0, 1'b1);
    send_item(16'h0009, 32'd100000, 32'd20000, 16'd1310, 1'b1);
    drain();

    // latency weight off so a violating path can score as high as a compliant one
    cfg_write(CFG_W_LAT, pad16('0));
    cfg_write(CFG_REQ_COMP, 32'd1);
    cfg_write(CFG_NONE, 32'hFFFF_FFFF);
    cfg_close();
    send_item(16'h0101, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0);
    send_item(16'h0202, 32'd10, 32'd10, 16'd10, 1'b1);
    send_item(16'h0303, 32'd60000, 32'd0, 16'd0, 1'b0);
    send_item(16'h0404, 32'd70000, 32'd0, 16'd0, 1'b1);
    drain();

    // zero limits normalize to nothing but still allow a zero measurement
    cfg_write(CFG_LAT_LIMIT, 32'd0);
    cfg_write(CFG_JIT_LIMIT, 32'hFFFF_FFFF);
    cfg_write(CFG_LOSS_LIMIT, pad16('0));
    cfg_write(CFG_W_LAT, pad16('1));
    cfg_write(CFG_W_JIT, pad16('1));
    cfg_write(CFG_W_LOSS, pad16('1));
    cfg_close();
    send_item(16'h0001, 32'd0, 32'd0, 16'd0, 1'b0);
    send_item(16'h0002, 32'd1, 32'hFFFF_FFFF, 16'd1, 1'b1);
    drain();

    // all weights zero
    cfg_write(CFG_W_LAT, pad16('0));
    cfg_write(CFG_W_JIT, pad16('0));
    cfg_write(CFG_W_LOSS, pad16('0));
    cfg_write(CFG_REQ_COMP, 32'hFFFF_FFFE);
    cfg_close();
    send_item(16'hAAAA, 32'd123, 32'd456, 16'd789, 1'b0);
    send_item(16'h5555, 32'd0, 32'd0, 16'd0, 1'b1);
    drain();

    cfg_write(CFG_LAT_LIMIT, 32'hFFFF_FFFF);
    cfg_write(CFG_JIT_LIMIT, 32'd1);
    cfg_write(CFG_LOSS_LIMIT, pad16('1));
    cfg_write(CFG_W_LAT, pad16(16'd1));
    cfg_write(CFG_W_JIT, pad16('1));
    cfg_write(CFG_W_LOSS, pad16(16'h0080));
    cfg_write(CFG_REQ_COMP, 32'd1);
    cfg_close();
    send_item(16'h0003, 32'hFFFF_FFFF, 32'd2, 16'hFFFF, 1'b0);
    send_item(16'h0004, 32'd0, 32'hFFFF_FFFF, 16'd0, 1'b1);
    drain();

    while (items_sent < ITEM_TARGET) begin
      random_config();
      if (phase_no == 2) begin
        // result side holds off while one-candidate sets keep coming
        hold_req = LONG_HOLD;
        repeat (8) begin
          send_item(ID_W'($urandom_range(0, 65535)), near_limit(lat_lim), near_limit(jit_lim),
                    near_loss(loss_lim), 1'b1);
        end
        drain();
      end
      random_sets($urandom_range(4, 12));
      if (items_sent >= CALM_FROM) calm = 1'b1;
      phase_no++;
    end

    if (fails == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/qps_pkg.sv
src/qps_if.sv
src/qps_cfg.sv
src/qps_div.sv
src/qps_seq.sv
src/qps_sel.sv
src/qos_path_score_select.sv
src/qps_checker.sv
bench/qps_checker.sv
bench/testbench.sv
